// ===== hw/rtl/bezier_point_evaluator_core_assert.svh =====
// assertion macros for the bezier point evaluator
// no dependencies; included by bezier_point_evaluator_core.sv to check its own logic
`ifndef BEZIER_POINT_EVALUATOR_CORE_ASSERT_SVH
`define BEZIER_POINT_EVALUATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define BPE_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bpe: same-cycle check failed");
`define BPE_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bpe: next-cycle check failed");
`define BPE_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("bpe: invariant check failed");
`else
`define BPE_ASSERT_IMPLY(lbl, clk, rst, pre, post)
`define BPE_ASSERT_NEXT(lbl, clk, rst, pre, post)
`define BPE_ASSERT_ALWAYS(lbl, clk, rst, cond)
`endif
`endif

// ===== hw/rtl/bpe_pkg.sv =====
// shared widths, types and constants of the bezier point evaluator
// no dependencies; imported by bpe_lerp, bezier_point_evaluator_core and the testbench
package bpe_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int PARAM_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = DIFF_WIDTH + PARAM_WIDTH;

   localparam int NUM_LEVELS  = 4;
   localparam int NUM_POINTS  = NUM_LEVELS + 1;
   localparam int NUM_STAGES  = 2 * NUM_LEVELS;
   localparam int T_STAGES    = NUM_STAGES - 2;

   localparam int DEG_WIDTH   = 3;
   localparam int SUM_WIDTH   = DEG_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic        [PARAM_WIDTH-1:0] param_type;
   typedef logic        [DEG_WIDTH-1:0]   degree_type;
   typedef logic        [NUM_LEVELS-1:0]  level_mask_type;

   localparam degree_type DEG_MIN   = degree_type'(1);
   localparam degree_type DEG_MAX   = degree_type'(NUM_LEVELS);
   localparam degree_type DEG_RESET = degree_type'(4);

   // load strobes of the two register stages inside one interpolation unit
   typedef struct packed {
      logic load_mul;
      logic load_sum;
   } stage_ctl_type;

endpackage

// ===== hw/rtl/bezier_point_evaluator_core.sv =====
// channel   | direction | handshake             | payload
// req_      | in        | req_valid / req_stall | five control points, curve parameter
// rsp_      | out       | rsp_valid / rsp_stall | curve point x and y
// csr_      | in        | csr_write_enable      | curve degree (3 bits)
//
// eight register stages: four de casteljau levels, each a multiply stage and an add stage
// one transaction per clock sustained while rsp_stall stays low
// the last stage is the output register; bubbles anywhere in the pipe are squeezed out
// under rsp_stall, so req_stall rises only when every stage holds a transaction
// synchronous active-high reset clears valid bits and sets the degree to quartic
// depends on bpe_pkg, bpe_lerp and bezier_point_evaluator_core_assert.svh
`include "bezier_point_evaluator_core_assert.svh"

module bezier_point_evaluator_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bpe_pkg::coord_type  req_p0_x,
   input  bpe_pkg::coord_type  req_p0_y,
   input  bpe_pkg::coord_type  req_p1_x,
   input  bpe_pkg::coord_type  req_p1_y,
   input  bpe_pkg::coord_type  req_p2_x,
   input  bpe_pkg::coord_type  req_p2_y,
   input  bpe_pkg::coord_type  req_p3_x,
   input  bpe_pkg::coord_type  req_p3_y,
   input  bpe_pkg::coord_type  req_p4_x,
   input  bpe_pkg::coord_type  req_p4_y,
   input  bpe_pkg::param_type  req_curve_param,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bpe_pkg::coord_type  rsp_point_x,
   output bpe_pkg::coord_type  rsp_point_y,
   input  logic                csr_write_enable,
   input  bpe_pkg::degree_type csr_write_data
);
   import bpe_pkg::*;

   // degree register, saturated to 1..4 where it is used
   degree_type degree_ff;
   degree_type degree_in;
   degree_type degree_sat;

   // per-stage valid bits and the ready chain running back from the output
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;

   // curve parameter and level bypass mask travelling with each transaction
   param_type      t_ff   [T_STAGES];
   level_mask_type byp_ff [T_STAGES];
   level_mask_type byp_entry;

   param_type      t_lvl   [NUM_LEVELS];
   level_mask_type byp_lvl [NUM_LEVELS];
   stage_ctl_type  ctl     [NUM_LEVELS];

   // points entering each level; level j works on NUM_POINTS - j of them
   coord_type pt_x [NUM_LEVELS+1][NUM_POINTS];
   coord_type pt_y [NUM_LEVELS+1][NUM_POINTS];

   // configuration register
   always_comb begin
      degree_in = csr_write_enable ? csr_write_data : degree_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEG_RESET;
      end else begin
         degree_ff <= degree_in;
      end
   end

   // zero acts as linear, five and above as quartic
   always_comb begin
      priority if (degree_ff < DEG_MIN) begin
         degree_sat = DEG_MIN;
      end else if (degree_ff > DEG_MAX) begin
         degree_sat = DEG_MAX;
      end else begin
         degree_sat = degree_ff;
      end
   end

   // a curve of degree d skips the first NUM_LEVELS - d levels, points pass unchanged
   always_comb begin
      for (int j = 0; j < NUM_LEVELS; j++) begin
         byp_entry[j] = (SUM_WIDTH'(j) + SUM_WIDTH'(degree_sat)) < SUM_WIDTH'(NUM_LEVELS);
      end
   end

   // a stage may load when it is empty or its successor moves on
   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int s = NUM_STAGES - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   assign req_stall = !ready[0];
   assign valid_in  = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // side band pipeline: curve parameter and bypass mask
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         t_ff[0]   <= req_curve_param;
         byp_ff[0] <= byp_entry;
      end
      for (int s = 1; s < T_STAGES; s++) begin
         if (ready[s]) begin
            t_ff[s]   <= t_ff[s-1];
            byp_ff[s] <= byp_ff[s-1];
         end
      end
   end

   // control points into the first level
   always_comb begin
      pt_x[0][0] = req_p0_x;
      pt_y[0][0] = req_p0_y;
      pt_x[0][1] = req_p1_x;
      pt_y[0][1] = req_p1_y;
      pt_x[0][2] = req_p2_x;
      pt_y[0][2] = req_p2_y;
      pt_x[0][3] = req_p3_x;
      pt_y[0][3] = req_p3_y;
      pt_x[0][4] = req_p4_x;
      pt_y[0][4] = req_p4_y;
   end

   // de casteljau levels, each a row of interpolation units for x and y
   for (genvar j = 0; j < NUM_LEVELS; j++) begin : g_level
      if (j == 0) begin : g_first
         assign t_lvl[j]   = req_curve_param;
         assign byp_lvl[j] = byp_entry;
      end else begin : g_later
         assign t_lvl[j]   = t_ff[2*j-1];
         assign byp_lvl[j] = byp_ff[2*j-1];
      end

      assign ctl[j].load_mul = ready[2*j];
      assign ctl[j].load_sum = ready[2*j+1];

      for (genvar i = 0; i < NUM_LEVELS - j; i++) begin : g_pair
         bpe_lerp u_lerp_x (
            .clock  (clock),
            .a      (pt_x[j][i]),
            .b      (pt_x[j][i+1]),
            .t      (t_lvl[j]),
            .bypass (byp_lvl[j][j]),
            .ctl    (ctl[j]),
            .result (pt_x[j+1][i])
         );
         bpe_lerp u_lerp_y (
            .clock  (clock),
            .a      (pt_y[j][i]),
            .b      (pt_y[j][i+1]),
            .t      (t_lvl[j]),
            .bypass (byp_lvl[j][j]),
            .ctl    (ctl[j]),
            .result (pt_y[j+1][i])
         );
      end

      // slots past the end of a shrinking level
      for (genvar i = NUM_LEVELS - j; i < NUM_POINTS; i++) begin : g_unused
         assign pt_x[j+1][i] = '0;
         assign pt_y[j+1][i] = '0;
      end
   end

   // the last add stage is the output register
   assign rsp_valid   = valid_ff[NUM_STAGES-1];
   assign rsp_point_x = pt_x[NUM_LEVELS][0];
   assign rsp_point_y = pt_y[NUM_LEVELS][0];

   // an accepted transaction always lands in the first stage
   `BPE_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, valid_ff[0])
   // back-pressure only when the output itself is held
   `BPE_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // a free output never blocks the input
   `BPE_ASSERT_IMPLY(a_free_flow, clock, reset, !rsp_stall, !req_stall)
   // the last level always runs, whatever the degree
   `BPE_ASSERT_ALWAYS(a_last_level_live, clock, reset, !byp_entry[NUM_LEVELS-1])

endmodule

// ===== hw/rtl/bpe_lerp.sv =====
// one two-stage fixed-point linear interpolation: a + ((b - a) * t) >>> PARAM_WIDTH
// with bypass set, a passes unchanged; depends on bpe_pkg
module bpe_lerp (
   input  logic                  clock,
   input  bpe_pkg::coord_type    a,
   input  bpe_pkg::coord_type    b,
   input  bpe_pkg::param_type    t,
   input  logic                  bypass,
   input  bpe_pkg::stage_ctl_type ctl,
   output bpe_pkg::coord_type    result
);
   import bpe_pkg::*;

   diff_type  diff;
   prod_type  prod_in;
   prod_type  prod_ff;
   prod_type  shifted;
   coord_type a_ff;
   coord_type res_in;
   coord_type res_ff;
   logic      byp_ff;

   always_comb begin
      diff    = DIFF_WIDTH'(b) - DIFF_WIDTH'(a);
      prod_in = PROD_WIDTH'(diff) * $signed(PROD_WIDTH'({1'b0, t}));
   end

   // floor division by the full scale of t
   always_comb begin
      shifted = prod_ff >>> PARAM_WIDTH;
      res_in  = byp_ff ? a_ff : coord_type'(a_ff + shifted[COORD_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         a_ff    <= a;
         prod_ff <= prod_in;
         byp_ff  <= bypass;
      end
      if (ctl.load_sum) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for bezier_point_evaluator_core: random and directed curves,
// predicted point per transaction by fixed-point de casteljau reduction
// depends on bpe_pkg and the core rtl only
module testbench;
   import bpe_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int PIPE_LATENCY  = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int ITEMS_PER_SET = 70;
   localparam int NUM_SETS      = 10;
   // degree per random set: every register value, extremes and out-of-range ones included
   localparam int SET_DEGREE [NUM_SETS] = '{1, 0, 4, 7, 2, 3, 5, 6, 4, 1};

   typedef struct packed {
      coord_type [NUM_POINTS-1:0] px;
      coord_type [NUM_POINTS-1:0] py;
      param_type                  t;
   } curve_req_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } curve_point_type;

   logic          clock            = 1'b0;
   logic          reset            = 1'b1;
   logic          req_valid        = 1'b0;
   logic          req_stall;
   logic          rsp_valid;
   logic          rsp_stall        = 1'b0;
   coord_type     rsp_point_x;
   coord_type     rsp_point_y;
   logic          csr_write_enable = 1'b0;
   degree_type    csr_write_data   = '0;
   curve_req_type req_item         = '0;

   curve_req_type   pending_curves [$];
   curve_point_type expected_points [$];
   degree_type      model_degree = DEG_RESET;
   logic            req_taken    = 1'b0;
   logic            flat_out     = 1'b0;
   int              gap_left     = 0;
   int              stall_left   = 0;
   int              mismatches   = 0;
   int              cycle_count  = 0;

   always #HALF_PERIOD clock = ~clock;

   bezier_point_evaluator_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_p0_x         (req_item.px[0]),
      .req_p0_y         (req_item.py[0]),
      .req_p1_x         (req_item.px[1]),
      .req_p1_y         (req_item.py[1]),
      .req_p2_x         (req_item.px[2]),
      .req_p2_y         (req_item.py[2]),
      .req_p3_x         (req_item.px[3]),
      .req_p3_y         (req_item.py[3]),
      .req_p4_x         (req_item.px[4]),
      .req_p4_y         (req_item.py[4]),
      .req_curve_param  (req_item.t),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // curve point by repeated lerp: a + floor((b - a) * t / 2^PARAM_WIDTH) per adjacent pair
   function automatic curve_point_type de_casteljau_point(input curve_req_type c,
                                                          input degree_type deg_reg);
      longint          xs [NUM_POINTS];
      longint          ys [NUM_POINTS];
      longint          t;
      int              levels;
      int              lvl;
      int              i;
      curve_point_type p;
      t = longint'(c.t);
      // degree saturates into 1..4
      if (deg_reg < DEG_MIN)
         levels = int'(DEG_MIN);
      else if (deg_reg > DEG_MAX)
         levels = int'(DEG_MAX);
      else
         levels = int'(deg_reg);
      for (i = 0; i < NUM_POINTS; i++) begin
         xs[i] = longint'($signed(c.px[i]));
         ys[i] = longint'($signed(c.py[i]));
      end
      for (lvl = levels; lvl > 0; lvl--) begin
         for (i = 0; i < lvl; i++) begin
            xs[i] = xs[i] + (((xs[i+1] - xs[i]) * t) >>> PARAM_WIDTH);
            ys[i] = ys[i] + (((ys[i+1] - ys[i]) * t) >>> PARAM_WIDTH);
         end
      end
      p.x = coord_type'(xs[0]);
      p.y = coord_type'(ys[0]);
      return p;
   endfunction

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 999);
      if (r < 600)
         return 0;
      else if (r < 900)
         return $urandom_range(1, 3);
      else if (r < 985)
         return $urandom_range(4, 10);
      else
         return $urandom_range(30, 60);
   endfunction

   // coordinate biased towards the range limits and towards tiny values
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 19))
         0:       return coord_type'(16'h7fff);
         1:       return coord_type'(16'h8000);
         2:       return coord_type'(int'($urandom_range(0, 31)) - 16);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic curve_req_type rand_curve();
      curve_req_type c;
      int            i;
      for (i = 0; i < NUM_POINTS; i++) begin
         c.px[i] = rand_coord();
         c.py[i] = rand_coord();
      end
      case ($urandom_range(0, 19))
         0:       c.t = '0;
         1:       c.t = '1;
         2:       c.t = param_type'($urandom_range(1, 15));
         default: c.t = param_type'($urandom);
      endcase
      return c;
   endfunction

   // x: even points at a, odd points at b; y the other way round
   function automatic curve_req_type zigzag_curve(input coord_type a, input coord_type b,
                                                  input param_type t);
      curve_req_type c;
      int            i;
      for (i = 0; i < NUM_POINTS; i++) begin
         c.px[i] = (i % 2 == 0) ? a : b;
         c.py[i] = (i % 2 == 0) ? b : a;
      end
      c.t = t;
      return c;
   endfunction

   // request driver: holds a stalled transaction, otherwise idles or takes the next curve
   always @(negedge clock) begin : feed_curves
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // not yet accepted, payload stays put
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pending_curves.size() > 0) begin
         req_item  <= pending_curves.pop_front();
         req_valid <= 1'b1;
         gap_left  <= flat_out ? 0 : pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result back-pressure, same idle profile as the sender
   always @(negedge clock) begin : hold_off_points
      int n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         n = flat_out ? 0 : pick_gap();
         rsp_stall  <= (n > 0);
         stall_left <= (n > 0) ? n - 1 : 0;
      end
   end

   // accepted requests: track the degree register and queue the predicted point
   always @(posedge clock) begin : watch_requests
      cycle_count <= cycle_count + 1;
      if (reset) begin
         model_degree <= DEG_RESET;
         req_taken    <= 1'b0;
      end else begin
         if (csr_write_enable)
            model_degree <= csr_write_data;
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_points.push_back(de_casteljau_point(req_item, model_degree));
      end
   end

   // accepted results: compare with the oldest prediction, field by field
   always @(posedge clock) begin : check_points
      curve_point_type want;
      logic            bad;
      bad = 1'b0;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d", $time, rsp_point_x, rsp_point_y);
            bad = 1'b1;
         end else begin
            want = expected_points.pop_front();
            if (rsp_point_x !== want.x) begin
               $display("%0t: point_x expected %0d, actual %0d", $time, want.x, rsp_point_x);
               bad = 1'b1;
            end
            if (rsp_point_y !== want.y) begin
               $display("%0t: point_y expected %0d, actual %0d", $time, want.y, rsp_point_y);
               bad = 1'b1;
            end
         end
      end
      if (bad)
         mismatches <= mismatches + 1;
   end

   // sender holds off until the pipe has delivered every predicted point
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_curves.size() != 0 || req_valid || expected_points.size() != 0);
   endtask

   task automatic write_degree(input degree_type d);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= d;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : run_timeout
      wait (cycle_count >= CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      curve_req_type c;
      int            set_idx;
      int            n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed curves at the reset degree (quartic)
      pending_curves.push_back(zigzag_curve('0, '0, '0));
      c = rand_curve();
      c.px[0] = coord_type'(16'h7fff);
      c.py[0] = coord_type'(16'h8000);
      c.t     = '0;
      pending_curves.push_back(c);           // t of zero gives point 0 exactly
      pending_curves.push_back(zigzag_curve(16'sh7fff, 16'sh7fff, '1));
      pending_curves.push_back(zigzag_curve(16'sh8000, 16'sh8000, '1));
      pending_curves.push_back(zigzag_curve(16'sh7fff, 16'sh8000, '1));
      pending_curves.push_back(zigzag_curve(16'sh8000, 16'sh7fff, 16'h0001));
      pending_curves.push_back(zigzag_curve(16'sh7fff, 16'sh8000, 16'h8000));
      pending_curves.push_back(zigzag_curve(16'sh5555, 16'shaaaa, 16'haaaa));
      pending_curves.push_back(zigzag_curve(16'shaaaa, 16'sh5555, 16'h5555));
      c = zigzag_curve('0, '0, '1);
      c.px[0] = coord_type'(16'h8000);
      c.py[0] = coord_type'(16'h7fff);
      c.px[4] = coord_type'(16'h7fff);
      c.py[4] = coord_type'(16'h8000);
      pending_curves.push_back(c);           // span the full range end to end
      c = zigzag_curve(16'sh0001, 16'shffff, 16'hffff);
      pending_curves.push_back(c);           // rounding of tiny negative steps
      wait_drained();

      // random sets, each under its own degree, a couple of them with no idling at all
      for (set_idx = 0; set_idx < NUM_SETS; set_idx++) begin
         write_degree(degree_type'(SET_DEGREE[set_idx]));
         flat_out = (set_idx == 3 || set_idx == 7);
         for (n = 0; n < ITEMS_PER_SET; n++)
            pending_curves.push_back(rand_curve());
         wait_drained();
      end

      // let any stray point out of the pipe before the verdict
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatches == 0 && expected_points.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
